[design/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset
`define SBB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger at one edge implies the consequence at the next edge
`define SBB_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[design/sbb_pkg.sv]
// ============================================================================
// sbb_pkg
// Shared types and constants of the separable box blur.
// ============================================================================
package sbb_pkg;

    // Default sizing of the frame and window
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_RADIUS_DEF = 15;

    // Register reset values
    localparam logic [3:0]  RST_RADIUS = 4'd5;
    localparam logic [10:0] RST_WIDTH  = 11'd480;
    localparam logic [10:0] RST_HEIGHT = 11'd270;

    localparam logic [7:0] ALPHA_FULL = 8'd255;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    // Item kinds on tuser
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // One blurred pixel, blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb8_t;

endpackage

[design/sbb_ram.sv]
// ============================================================================
// sbb_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ============================================================================
module sbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/sbb_div.sv]
// ============================================================================
// sbb_div
// Three-lane restoring divider: window sum over window size, 8-bit quotient.
// ============================================================================
module sbb_div import sbb_pkg::*; #(
    parameter int ACC_W = 13,
    parameter int WIN_W = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WIN_W-1:0]      divisor,
    input  logic [2:0][ACC_W-1:0] dividend,
    output logic                  done,
    output rgb8_t                 quot
);

    localparam int CMP_W = ACC_W + 8;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [2:0]            bit_reg, bit_next;
    logic [WIN_W-1:0]      div_reg, div_next;
    logic [2:0][ACC_W-1:0] rem_reg, rem_next;
    logic [2:0][7:0]       q_reg, q_next;
    logic [CMP_W-1:0]      dsh;

    // Divisor aligned to the current quotient bit
    assign dsh = CMP_W'(div_reg) << bit_reg;

    // One quotient bit per cycle, from bit 7 down
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = 3'd7;
            div_next  = divisor;
            rem_next  = dividend;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                if (CMP_W'(rem_reg[ch]) >= dsh)
                begin
                    rem_next[ch]       = rem_reg[ch] - ACC_W'(dsh);
                    q_next[ch][bit_reg] = 1'b1;
                end
            end
            if (bit_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                bit_next = bit_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done       = done_reg;
    assign quot.blue  = q_reg[0];
    assign quot.green = q_reg[1];
    assign quot.red   = q_reg[2];

endmodule

[design/separable_box_blur_rgb.sv]
// ============================================================================
// separable_box_blur_rgb
// Clamp-to-edge separable box blur of a raster BGRA pixel stream.
// ============================================================================
// Usage:
//   Input stream s_*: one transaction per pixel (tuser = 0) or flush step
//   (tuser = 1). Output stream m_*: blurred pixels, tlast on the frame's last.
//   Config channel cfg_*: write radius, width or height between frames; a
//   write restarts the frame position. Input is held off after it.
//   The result for raster index j leaves on transaction j + r*W + r; flush
//   steps drain the final r*W + r results.
//   One item is processed at a time. Each row-blurred column is made by
//   2r+1 row memory reads, a drain step, a divider start and its wait.
//   The column blur of a result repeats that sequence from the line memory,
//   then loads the output register. An item first finishes its row-blurred
//   columns, then blurs its result if it yields one; most pixels finish one
//   column, the last pixel of a row finishes r+1 (all W when W <= r).
//   An ignored flush goes straight back to idle. Bypass (r = 0, W = 1 or
//   H = 1) passes a pixel unchanged to the output register.
//   Reset: radius 5, 480 x 270, frame position zero; memories are not
//   cleared, every entry is written before it is read.
//   A stalled receiver holds the output register; the next item is still
//   taken and worked on up to the point where its result is loaded.
// ============================================================================
module separable_box_blur_rgb import sbb_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // blue_in, green_in, red_in, alpha_in
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // blue_out, green_out, red_out, alpha_out
    output logic        m_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    // Output rows lag input rows by up to r + r/W + 1, so the ring spans 3r+2
    localparam int RING       = 3 * MAX_RADIUS + 2;
    localparam int SLOT_W     = $clog2(RING);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int WIN_W      = $clog2(2 * MAX_RADIUS + 2);
    localparam int ACC_W      = $clog2(255 * (2 * MAX_RADIUS + 1) + 1);
    localparam int POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + (MAX_RADIUS + 1) * MAX_WIDTH);
    localparam int RW_W       = RAD_W + WID_W + 1;
    localparam int AREA_W     = WID_W + HGT_W;
    localparam int IDX_W      = ((WID_W > WIN_W) ? WID_W : WIN_W) + 2;
    localparam int VIDX_W     = ((HGT_W > WIN_W) ? HGT_W : WIN_W) + 2;
    localparam int LINE_DEPTH = RING * MAX_WIDTH;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_HTAP, S_HDRAIN, S_HSTART, S_HWAIT, S_VCHK,
        S_VTAP, S_VDRAIN, S_VSTART, S_VWAIT, S_EMIT, S_ADV
    } state_t;

    // Config registers and derived frame constants
    logic [3:0]        radius_reg, radius_next;
    logic [10:0]       width_reg, width_next;
    logic [10:0]       height_reg, height_next;
    logic [1:0]        settle_reg, settle_next;
    logic [RAD_W-1:0]  r_lim, r_eff_reg;
    logic [WID_W-1:0]  w_lim, w_eff_reg;
    logic [HGT_W-1:0]  h_lim, h_eff_reg;
    logic [AREA_W-1:0] area;
    logic [RW_W-1:0]   rw_sum;
    logic [POS_W-1:0]  n_reg, d_reg, last_reg;
    logic [WIN_W-1:0]  win_reg;
    logic              bypass_reg;

    // Sequencer state
    state_t                state_reg, state_next;
    logic                  func_reg, func_next;
    logic [31:0]           pix_reg, pix_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [SLOT_W-1:0]     in_slot_reg, in_slot_next;
    logic [COL_W-1:0]      out_x_reg, out_x_next;
    logic [ROW_W-1:0]      out_y_reg, out_y_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [COL_W-1:0]      h_col_reg, h_col_next;
    logic [COL_W-1:0]      h_hi_reg, h_hi_next;
    logic [WIN_W-1:0]      tap_reg, tap_next;
    logic                  rdv_reg, rdv_next;
    logic [2:0][ACC_W-1:0] acc_reg, acc_next;
    logic [31:0]           res_data_reg, res_data_next;
    logic                  res_last_reg, res_last_next;
    logic                  m_valid_reg, m_valid_next;
    logic [31:0]           m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    // Memory ports
    logic                row_we;
    logic [COL_W-1:0]    row_raddr;
    logic [23:0]         row_rdata;
    logic                line_we;
    logic [LINE_AW-1:0]  line_waddr, line_raddr;
    logic [23:0]         line_rdata;
    logic [23:0]         tap_data;

    // Address generation
    logic signed [IDX_W-1:0]  h_raw;
    logic signed [VIDX_W-1:0] v_raw, v_row, v_slot_raw;
    logic [SLOT_W-1:0]        v_slot;
    logic                     tap_last;
    logic                     col_ge_r, col_is_last;

    // Divider
    logic  div_start, div_done;
    rgb8_t quot;

    // ------------------------------------------------------------------
    // Effective register values, limited to the supported range
    assign r_lim = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_reg);
    assign w_lim = (width_reg == '0) ? WID_W'(1) :
                   (int'(width_reg) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(width_reg);
    assign h_lim = (height_reg == '0) ? HGT_W'(1) :
                   (int'(height_reg) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : HGT_W'(height_reg);

    assign area   = AREA_W'(w_eff_reg) * AREA_W'(h_eff_reg);
    assign rw_sum = RW_W'(r_eff_reg) * RW_W'(w_eff_reg) + RW_W'(r_eff_reg);

    // Three-stage settle pipeline for frame constants
    always_ff @(posedge clk)
    begin
        r_eff_reg  <= r_lim;
        w_eff_reg  <= w_lim;
        h_eff_reg  <= h_lim;
        win_reg    <= WIN_W'({r_eff_reg, 1'b1});
        bypass_reg <= (r_eff_reg == '0) || (w_eff_reg == WID_W'(1)) || (h_eff_reg == HGT_W'(1));
        n_reg      <= POS_W'(area);
        d_reg      <= POS_W'(rw_sum);
        last_reg   <= n_reg + d_reg - POS_W'(1);
    end

    // ------------------------------------------------------------------
    // Row-blur tap: clamped column of the current input row
    assign h_raw = IDX_W'(h_col_reg) + IDX_W'(tap_reg) - IDX_W'(r_eff_reg);
    always_comb
    begin
        if (h_raw < 0)
        begin
            row_raddr = '0;
        end
        else if (h_raw >= $signed(IDX_W'(w_eff_reg)))
        begin
            row_raddr = COL_W'(w_eff_reg - WID_W'(1));
        end
        else
        begin
            row_raddr = COL_W'(h_raw);
        end
    end

    // Column-blur tap: clamped row, mapped to its ring slot
    assign v_raw = VIDX_W'(out_y_reg) + VIDX_W'(tap_reg) - VIDX_W'(r_eff_reg);
    always_comb
    begin
        if (v_raw < 0)
        begin
            v_row = '0;
        end
        else if (v_raw >= $signed(VIDX_W'(h_eff_reg)))
        begin
            v_row = $signed(VIDX_W'(h_eff_reg)) - VIDX_W'(1);
        end
        else
        begin
            v_row = v_raw;
        end
        v_slot_raw = VIDX_W'(out_slot_reg) + v_row - VIDX_W'(out_y_reg);
        if (v_slot_raw < 0)
        begin
            v_slot = SLOT_W'(v_slot_raw + VIDX_W'(RING));
        end
        else if (v_slot_raw >= $signed(VIDX_W'(RING)))
        begin
            v_slot = SLOT_W'(v_slot_raw - VIDX_W'(RING));
        end
        else
        begin
            v_slot = SLOT_W'(v_slot_raw);
        end
    end

    assign line_raddr = LINE_AW'(int'(v_slot) * MAX_WIDTH + int'(out_x_reg));
    assign line_waddr = LINE_AW'(int'(in_slot_reg) * MAX_WIDTH + int'(h_col_reg));

    assign tap_last    = (tap_reg == win_reg - WIN_W'(1));
    assign col_ge_r    = (int'(in_col_reg) >= int'(r_eff_reg));
    assign col_is_last = (int'(in_col_reg) == int'(w_eff_reg) - 1);

    // Tap data source follows the pass being summed
    assign tap_data = ((state_reg == S_VTAP) || (state_reg == S_VDRAIN)) ? line_rdata : row_rdata;

    assign div_start = (state_reg == S_HSTART) || (state_reg == S_VSTART);

    // ------------------------------------------------------------------
    // Sequencer
    always_comb
    begin
        radius_next   = radius_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        settle_next   = (settle_reg != 2'd0) ? settle_reg - 2'd1 : settle_reg;
        state_next    = state_reg;
        func_next     = func_reg;
        pix_next      = pix_reg;
        pos_next      = pos_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_slot_next = out_slot_reg;
        h_col_next    = h_col_reg;
        h_hi_next     = h_hi_reg;
        tap_next      = tap_reg;
        rdv_next      = 1'b0;
        acc_next      = acc_reg;
        res_data_next = res_data_reg;
        res_last_next = res_last_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        row_we        = 1'b0;
        line_we       = 1'b0;

        // Sum the tap read issued last cycle
        if (rdv_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                acc_next[ch] = acc_reg[ch] + ACC_W'(tap_data[8*ch +: 8]);
            end
        end

        // Output register drains on a taken transaction
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    settle_next = 2'd3;
                    case (cfg_reg_t'(cfg_index))
                        REG_RADIUS: radius_next = cfg_data[3:0];
                        REG_WIDTH:  width_next  = cfg_data;
                        REG_HEIGHT: height_next = cfg_data;
                        default:    settle_next = 2'd3;
                    endcase
                    if ((cfg_reg_t'(cfg_index) == REG_RADIUS) ||
                        (cfg_reg_t'(cfg_index) == REG_WIDTH) ||
                        (cfg_reg_t'(cfg_index) == REG_HEIGHT))
                    begin
                        pos_next      = '0;
                        in_col_next   = '0;
                        in_slot_next  = '0;
                        out_x_next    = '0;
                        out_y_next    = '0;
                        out_slot_next = '0;
                    end
                end
                else if (s_tvalid && s_tready)
                begin
                    func_next  = s_tuser[0];
                    pix_next   = s_tdata;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (bypass_reg)
                begin
                    if (func_reg == FUNC_FLUSH)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_data_next = pix_reg;
                        res_last_next = ((POS_W+1)'(pos_reg) + (POS_W+1)'(1)) >=
                                        (POS_W+1)'(n_reg);
                        state_next    = S_EMIT;
                    end
                end
                else if (pos_reg < n_reg)
                begin
                    if (func_reg == FUNC_FLUSH)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_we = 1'b1;
                        if (col_ge_r || col_is_last)
                        begin
                            h_col_next = col_ge_r ? COL_W'(int'(in_col_reg) - int'(r_eff_reg))
                                                  : '0;
                            h_hi_next  = col_is_last ? COL_W'(w_eff_reg - WID_W'(1))
                                                     : COL_W'(int'(in_col_reg) - int'(r_eff_reg));
                            tap_next   = '0;
                            acc_next   = '0;
                            state_next = S_HTAP;
                        end
                        else
                        begin
                            state_next = S_VCHK;
                        end
                    end
                end
                else
                begin
                    state_next = S_VCHK;
                end
            end

            // Horizontal window over the input row
            S_HTAP:
            begin
                rdv_next = 1'b1;
                if (tap_last)
                begin
                    state_next = S_HDRAIN;
                end
                else
                begin
                    tap_next = tap_reg + WIN_W'(1);
                end
            end

            S_HDRAIN: state_next = S_HSTART;

            S_HSTART: state_next = S_HWAIT;

            S_HWAIT:
            begin
                if (div_done)
                begin
                    line_we = 1'b1;
                    if (h_col_reg == h_hi_reg)
                    begin
                        state_next = S_VCHK;
                    end
                    else
                    begin
                        h_col_next = h_col_reg + COL_W'(1);
                        tap_next   = '0;
                        acc_next   = '0;
                        state_next = S_HTAP;
                    end
                end
            end

            S_VCHK:
            begin
                if (pos_reg >= d_reg)
                begin
                    tap_next   = '0;
                    acc_next   = '0;
                    state_next = S_VTAP;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end

            // Vertical window over the line store
            S_VTAP:
            begin
                rdv_next = 1'b1;
                if (tap_last)
                begin
                    state_next = S_VDRAIN;
                end
                else
                begin
                    tap_next = tap_reg + WIN_W'(1);
                end
            end

            S_VDRAIN: state_next = S_VSTART;

            S_VSTART: state_next = S_VWAIT;

            S_VWAIT:
            begin
                if (div_done)
                begin
                    res_data_next = {ALPHA_FULL, quot};
                    res_last_next = (pos_reg == last_reg);
                    state_next    = S_EMIT;
                end
            end

            // Load the output register once it is free
            S_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_last_next  = res_last_reg;
                    state_next   = S_ADV;
                end
            end

            // Step the frame position
            S_ADV:
            begin
                state_next = S_IDLE;
                if (bypass_reg)
                begin
                    pos_next = res_last_reg ? '0 : pos_reg + POS_W'(1);
                end
                else if (pos_reg == last_reg)
                begin
                    pos_next      = '0;
                    in_col_next   = '0;
                    in_slot_next  = '0;
                    out_x_next    = '0;
                    out_y_next    = '0;
                    out_slot_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_reg < n_reg)
                    begin
                        if (col_is_last)
                        begin
                            in_col_next  = '0;
                            in_slot_next = (int'(in_slot_reg) == RING - 1) ? '0
                                         : in_slot_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                    end
                    if (pos_reg >= d_reg)
                    begin
                        if (int'(out_x_reg) == int'(w_eff_reg) - 1)
                        begin
                            out_x_next    = '0;
                            out_y_next    = out_y_reg + ROW_W'(1);
                            out_slot_next = (int'(out_slot_reg) == RING - 1) ? '0
                                          : out_slot_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            out_x_next = out_x_reg + COL_W'(1);
                        end
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RST_RADIUS;
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            settle_reg   <= 2'd3;
            state_reg    <= S_IDLE;
            func_reg     <= FUNC_PIXEL;
            pix_reg      <= '0;
            pos_reg      <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_slot_reg <= '0;
            h_col_reg    <= '0;
            h_hi_reg     <= '0;
            tap_reg      <= '0;
            rdv_reg      <= 1'b0;
            acc_reg      <= '0;
            res_data_reg <= '0;
            res_last_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            radius_reg   <= radius_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            settle_reg   <= settle_next;
            state_reg    <= state_next;
            func_reg     <= func_next;
            pix_reg      <= pix_next;
            pos_reg      <= pos_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_slot_reg <= out_slot_next;
            h_col_reg    <= h_col_next;
            h_hi_reg     <= h_hi_next;
            tap_reg      <= tap_next;
            rdv_reg      <= rdv_next;
            acc_reg      <= acc_next;
            res_data_reg <= res_data_next;
            res_last_reg <= res_last_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
            m_last_reg   <= m_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Current input row
    sbb_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (in_col_reg),
        .wdata (pix_reg[23:0]),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Ring of row-blurred lines
    sbb_ram #(
        .WIDTH (24),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (quot),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Shared window divider for both passes
    sbb_div #(
        .ACC_W (ACC_W),
        .WIN_W (WIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (win_reg),
        .dividend (acc_reg),
        .done     (div_done),
        .quot     (quot)
    );

    // Handshakes
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && (settle_reg == 2'd0) && !cfg_valid;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

endmodule

[design/sbb_checker.sv]
// ============================================================================
// sbb_checker
// Port-level checks of the box blur, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module sbb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A stalled result holds its payload
    `SBB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // Config and input never complete in the same cycle
    `SBB_ASSERT(a_cfg_excl, !(cfg_valid && cfg_ready && s_tvalid && s_tready), "config and input transaction together")

    // Input is held off while new frame constants settle
    `SBB_ASSERT_NEXT(a_cfg_settle, cfg_valid && cfg_ready, !s_tready, "input ready right after config write")

    // One item at a time
    `SBB_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input ready right after an input transaction")

endmodule

bind separable_box_blur_rgb sbb_checker u_sbb_checker (.*);

[tb/sv/separable_box_blur_rgb_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// separable_box_blur_rgb_tb
// Self-checking bench for the box blur: drives pixel and flush transactions
// across a series of frame setups and idle patterns. A behavioral blur model
// or the directed table gives each result; each output is compared with it.
// ============================================================================
module separable_box_blur_rgb_tb;
    import sbb_pkg::*;

    localparam int RING_ROWS   = 3 * MAX_RADIUS_DEF + 2;
    localparam int SETTLE_CYC  = 800;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] pix;
        logic        last;
    } blur_exp_t;

    // One directed step: a register write or an item, optionally with its result
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [10:0] val;
        logic        func;
        logic [31:0] pix;
        logic        chk;
        logic [31:0] exp_pix;
        logic        exp_last;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // bypass frame of 4 x 2: pixels return unchanged
        '{1'b1, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_WIDTH,  11'd4, FUNC_PIXEL, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_HEIGHT, 11'd2, FUNC_PIXEL, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h5A5A5A5A, 1'b1, 32'h5A5A5A5A, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_FLUSH, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h01234567, 1'b1, 32'h01234567, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h89ABCDEF, 1'b1, 32'h89ABCDEF, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h7F80FF00, 1'b1, 32'h7F80FF00, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h0000FFFF, 1'b1, 32'h0000FFFF, 1'b1},
        // radius 1 on a 2 x 2 white frame, with early flush and tail pixel
        '{1'b1, REG_RADIUS, 11'd1, FUNC_PIXEL, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_WIDTH,  11'd2, FUNC_PIXEL, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_HEIGHT, 11'd2, FUNC_PIXEL, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_FLUSH, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h00FFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_FLUSH, 32'h0, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_PIXEL, 32'h12345678, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{1'b0, REG_RADIUS, 11'd0, FUNC_FLUSH, 32'h0, 1'b1, 32'hFFFFFFFF, 1'b1}
    };

    // Random phases: radius, width, height, items, idle pattern
    localparam int PHASES = 11;
    localparam int PH_RAD  [PHASES] = '{1, 2, 15, 3, 15, 0, 4, 7, 5, 6, 1};
    localparam int PH_WID  [PHASES] = '{3, 7, 2, 4, 16, 5, 0, 2047, 1024, 9, 2};
    localparam int PH_HGT  [PHASES] = '{3, 5, 2, 6, 3, 5, 9, 1, 1024, 0, 2};
    localparam int PH_ITEMS[PHASES] = '{80, 100, 100, 100, 120, 60, 40, 40, 30, 40, 60};
    localparam int PH_MODE [PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 3};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    separable_box_blur_rgb u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Blur model state
    logic [3:0]  mdl_radius;
    logic [10:0] mdl_width;
    logic [10:0] mdl_height;
    int          mdl_pos;
    logic [23:0] mdl_row   [MAX_WIDTH_DEF];
    logic [23:0] mdl_ring  [RING_ROWS * MAX_WIDTH_DEF];

    blur_exp_t   pending_pix[$];
    int          err_count;
    int          cyc_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_dim(logic [10:0] v);
        if (v < 1) return 1;
        if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return v;
    endfunction

    function automatic int clamp_to(int v, int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    // Horizontal box of one column of the current row into the line ring
    function automatic void row_box(int yy, int xx, int r, int w);
        int          sum;
        logic [23:0] acc;
        acc = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int t = -r; t <= r; t++)
                sum += mdl_row[clamp_to(xx + t, w)][8*ch +: 8];
            acc[8*ch +: 8] = sum / (2 * r + 1);
        end
        mdl_ring[(yy % RING_ROWS) * MAX_WIDTH_DEF + xx] = acc;
    endfunction

    // Advance the blur model by one accepted item
    task automatic blur_predict(input logic fn, input logic [31:0] px,
                                output bit got, output blur_exp_t res);
        int r, w, h, n, k, d, lst, yy, c, y, x, j, sum;
        r = mdl_radius;
        w = eff_dim(mdl_width);
        h = eff_dim(mdl_height);
        n = w * h;
        k = mdl_pos;
        got = 0;
        res.pix = '0;
        res.last = 1'b0;
        if (r == 0 || w == 1 || h == 1)
        begin
            if (fn == FUNC_FLUSH)
                return;
            res.pix = px;
            res.last = (k + 1 >= n);
            mdl_pos = res.last ? 0 : k + 1;
            got = 1;
            return;
        end
        d = r * w + r;
        lst = n - 1 + d;
        if (k < n)
        begin
            if (fn == FUNC_FLUSH)
                return;
            yy = k / w;
            c = k % w;
            mdl_row[c] = px[23:0];
            if (c >= r)
                row_box(yy, c - r, r, w);
            if (c == w - 1)
                for (x = (w > r) ? w - r : 0; x < w; x++)
                    row_box(yy, x, r, w);
        end
        if (k >= d)
        begin
            j = k - d;
            y = j / w;
            x = j % w;
            for (int ch = 0; ch < 3; ch++)
            begin
                sum = 0;
                for (int t = -r; t <= r; t++)
                    sum += mdl_ring[(clamp_to(y + t, h) % RING_ROWS) * MAX_WIDTH_DEF
                                    + x][8*ch +: 8];
                res.pix[8*ch +: 8] = sum / (2 * r + 1);
            end
            res.pix[31:24] = ALPHA_FULL;
            res.last = (k == lst);
            got = 1;
        end
        mdl_pos = (k == lst) ? 0 : k + 1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] seen);
        $display("[%0t] mismatch %s: expected %0h, got %0h", $time, what, want, seen);
        err_count++;
    endtask

    // Wait for the output to drain, then for any silent work to finish
    task automatic wait_drained();
        while (pending_pix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RADIUS: mdl_radius = val[3:0];
            REG_WIDTH:  mdl_width  = val;
            REG_HEIGHT: mdl_height = val;
            default: ;
        endcase
        if (idx != REG_UNUSED)
            mdl_pos = 0;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drive one item; returns the model's result for it
    task automatic send_item(logic fn, logic [31:0] px, output bit got,
                             output blur_exp_t res);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = px;
        do
            @(posedge clk);
        while (!s_tready);
        blur_predict(fn, px, got, res);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Receiver stall pattern
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= recv_stall_pct);

    // Output checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pix.size() == 0)
                report_mismatch("unexpected transaction", 32'h0, m_tdata);
            else
            begin
                blur_exp_t e;
                e = pending_pix.pop_front();
                if (e.pix[7:0] !== m_tdata[7:0])
                    report_mismatch("blue", e.pix[7:0], m_tdata[7:0]);
                if (e.pix[15:8] !== m_tdata[15:8])
                    report_mismatch("green", e.pix[15:8], m_tdata[15:8]);
                if (e.pix[23:16] !== m_tdata[23:16])
                    report_mismatch("red", e.pix[23:16], m_tdata[23:16]);
                if (e.pix[31:24] !== m_tdata[31:24])
                    report_mismatch("alpha", e.pix[31:24], m_tdata[31:24]);
                if (e.last !== m_tlast)
                    report_mismatch("frame end", e.last, m_tlast);
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cyc_count++;
        if (cyc_count > CYCLE_LIMIT)
        begin
            $display("separable_box_blur_rgb_tb: errors");
            $finish;
        end
    end

    initial
    begin
        bit          got;
        blur_exp_t   res;
        logic        fn;
        logic [31:0] px;
        int          w, h, n;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_PIXEL;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        err_count = 0;
        cyc_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mdl_radius = RST_RADIUS;
        mdl_width = RST_WIDTH;
        mdl_height = RST_HEIGHT;
        mdl_pos = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A few pixels into the reset-size frame; far too early for results
        for (int i = 0; i < 4; i++)
        begin
            send_item(FUNC_PIXEL, $urandom, got, res);
            if (got)
                pending_pix.push_back(res);
        end

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].is_cfg)
            begin
                wait_drained();
                write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].val);
            end
            else
            begin
                send_item(DIR_TABLE[i].func, DIR_TABLE[i].pix, got, res);
                if (DIR_TABLE[i].chk)
                begin
                    res.pix  = DIR_TABLE[i].exp_pix;
                    res.last = DIR_TABLE[i].exp_last;
                    pending_pix.push_back(res);
                end
                else if (got)
                    pending_pix.push_back(res);
            end
        end

        // Random phases
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            wait_drained();
            if (p == 3)
                write_reg(REG_UNUSED, 11'($urandom));
            write_reg(REG_RADIUS, 11'(PH_RAD[p]));
            write_reg(REG_WIDTH, 11'(PH_WID[p]));
            write_reg(REG_HEIGHT, 11'(PH_HGT[p]));
            case (PH_MODE[p])
                1: send_idle_pct = 76;
                2: recv_stall_pct = 76;
                3: begin send_idle_pct = 38; recv_stall_pct = 38; end
                default: ;
            endcase
            w = eff_dim(mdl_width);
            h = eff_dim(mdl_height);
            n = w * h;
            for (int i = 0; i < PH_ITEMS[p]; i++)
            begin
                // halfway through, hold the input until the output has fully drained
                if (i == PH_ITEMS[p] / 2)
                    while (pending_pix.size() != 0)
                        @(posedge clk);
                // mostly well-formed frames: pixels, then flushes for the tail
                if (mdl_radius == 0 || w == 1 || h == 1)
                    fn = ($urandom_range(99) < 85) ? FUNC_PIXEL : FUNC_FLUSH;
                else if (mdl_pos < n)
                    fn = ($urandom_range(99) < 90) ? FUNC_PIXEL : FUNC_FLUSH;
                else
                    fn = ($urandom_range(99) < 90) ? FUNC_FLUSH : FUNC_PIXEL;
                px = $urandom;
                send_item(fn, px, got, res);
                if (got)
                    pending_pix.push_back(res);
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (err_count == 0)
            $display("separable_box_blur_rgb_tb: clean");
        else
            $display("separable_box_blur_rgb_tb: errors");
        $finish;
    end

endmodule
